[hw/rtl/rcsat_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcsat_pkg
// Types and constants shared by the satellite receiver frame decoder.
// ----------------------------------------------------------------------------
package rcsat_pkg;

  localparam int unsigned NumChannelsDef = 9;
  localparam int unsigned FrameBytesDef  = 16;

  localparam int unsigned OutChans   = 9;
  localparam int unsigned ChanW      = 12;
  localparam int unsigned RawW       = 11;
  localparam int unsigned IdW        = 5;
  localparam int unsigned OffsetW    = 11;
  localparam int unsigned TimeoutW   = 15;
  localparam int unsigned TicksW     = 16;
  localparam int unsigned CfgIdxW    = 2;
  localparam int unsigned CfgDataW   = 16;

  localparam logic [OffsetW-1:0]  OffsetRst  = OffsetW'(342);
  localparam logic [TimeoutW-1:0] TimeoutRst = TimeoutW'(1000);

  typedef enum logic [CfgIdxW-1:0] {
    CFG_VALUE_OFFSET = 2'd0,
    CFG_TIMEOUT_MS   = 2'd1
  } cfg_idx_e;

  typedef enum logic {
    ACT_BYTE = 1'b0,
    ACT_TICK = 1'b1
  } action_e;

  typedef struct packed {
    logic       action;
    logic [7:0] data_byte;
  } rcsat_in_t;

  typedef struct packed {
    logic signed [ChanW-1:0] chan0;
    logic signed [ChanW-1:0] chan1;
    logic signed [ChanW-1:0] chan2;
    logic signed [ChanW-1:0] chan3;
    logic signed [ChanW-1:0] chan4;
    logic signed [ChanW-1:0] chan5;
    logic signed [ChanW-1:0] chan6;
    logic signed [ChanW-1:0] chan7;
    logic signed [ChanW-1:0] chan8;
    logic                    frame_done;
    logic                    link_ok;
  } rcsat_out_t;

  typedef struct packed {
    logic [OffsetW-1:0]  value_offset;
    logic [TimeoutW-1:0] timeout_ms;
  } rcsat_cfg_t;

endpackage

[hw/rtl/rc_satellite_frame_decoder_top.sv]
`timescale 1ns / 1ps
// a result beat is registered at the output, or in the skid stage while it stalls
// throughput: one item per cycle while in_stall_o is low; the result register
//   plus a one-entry skid stage take one stalled beat before in_stall_o rises
// reset: asynchronous active low; clears channels, byte position, pair latch,
//   tick count, output valids; offset and timeout return to 342 and 1000
// ----------------------------------------------------------------------------
// rc_satellite_frame_decoder_top
// Decodes 16-byte satellite receiver frames into nine channel values and
// tracks link health from a millisecond tick.
// ----------------------------------------------------------------------------
module rc_satellite_frame_decoder_top import rcsat_pkg::*; #(
  parameter int unsigned NUM_CHANNELS = NumChannelsDef,
  parameter int unsigned FRAME_BYTES  = FrameBytesDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  rcsat_in_t           in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output rcsat_out_t          out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  rcsat_cfg_t cfg;
  rcsat_out_t result;
  logic       accept;
  logic       full;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = full;
  assign accept      = in_valid_i && !full;

  rcsat_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  rcsat_decode #(
    .NUM_CHANNELS (NUM_CHANNELS),
    .FRAME_BYTES  (FRAME_BYTES)
  ) u_decode (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .in_data_i (in_data_i),
    .cfg_i     (cfg),
    .result_o  (result)
  );

  rcsat_outbuf u_outbuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (accept),
    .push_data_i (result),
    .full_o      (full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

[hw/rtl/rcsat_cfg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcsat_cfg
// Configuration registers: value offset and link timeout.
// ----------------------------------------------------------------------------
module rcsat_cfg import rcsat_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output rcsat_cfg_t          cfg_o
);

  rcsat_cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_VALUE_OFFSET: cfg_d.value_offset = cfg_data_i[OffsetW-1:0];
        CFG_TIMEOUT_MS:   cfg_d.timeout_ms   = cfg_data_i[TimeoutW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.value_offset <= OffsetRst;
      cfg_q.timeout_ms   <= TimeoutRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

[hw/rtl/rcsat_decode.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcsat_decode
// Frame byte counter, word assembly, channel store and tick counter.
// Produces the result beat from the updated state in the accept cycle.
// ----------------------------------------------------------------------------
module rcsat_decode import rcsat_pkg::*; #(
  parameter int unsigned NUM_CHANNELS = NumChannelsDef,
  parameter int unsigned FRAME_BYTES  = FrameBytesDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  rcsat_in_t  in_data_i,
  input  rcsat_cfg_t cfg_i,
  output rcsat_out_t result_o
);

  localparam int unsigned PosW = $clog2(FRAME_BYTES);

  logic [PosW-1:0]   pos_q, pos_d;
  logic [7:0]        high_q, high_d;
  logic [TicksW-1:0] ticks_q, ticks_d;
  logic [ChanW-1:0]  store_q [NUM_CHANNELS];
  logic [ChanW-1:0]  store_d [NUM_CHANNELS];

  logic              is_tick;
  logic              last_byte;
  logic              word_done;
  logic [IdW-1:0]    word_id;
  logic [ChanW-1:0]  word_val;
  logic              done;
  logic [ChanW-1:0]  chans [OutChans];

  assign is_tick   = (action_e'(in_data_i.action) == ACT_TICK);
  assign last_byte = (pos_q == PosW'(FRAME_BYTES - 1));
  // second byte of a pair, past the two header bytes
  assign word_done = !is_tick && (pos_q >= PosW'(2)) && pos_q[0];
  assign word_id   = high_q[7:3];
  assign word_val  = {1'b0, high_q[2:0], in_data_i.data_byte}
                   - {1'b0, cfg_i.value_offset};
  assign done      = !is_tick && last_byte;

  always_comb begin
    pos_d   = pos_q;
    high_d  = high_q;
    ticks_d = ticks_q;
    if (is_tick) begin
      if (ticks_q != '1) begin
        ticks_d = ticks_q + TicksW'(1);
      end
    end else begin
      if ((pos_q >= PosW'(2)) && !pos_q[0]) begin
        high_d = in_data_i.data_byte;
      end
      if (last_byte) begin
        pos_d   = '0;
        ticks_d = '0;
      end else begin
        pos_d = pos_q + PosW'(1);
      end
    end
  end

  always_comb begin
    for (int k = 0; k < NUM_CHANNELS; k++) begin
      store_d[k] = store_q[k];
      if (word_done && (word_id == IdW'(k))) begin
        store_d[k] = word_val;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      high_q  <= '0;
      ticks_q <= '0;
      for (int k = 0; k < NUM_CHANNELS; k++) begin
        store_q[k] <= '0;
      end
    end else if (accept_i) begin
      pos_q   <= pos_d;
      high_q  <= high_d;
      ticks_q <= ticks_d;
      for (int k = 0; k < NUM_CHANNELS; k++) begin
        store_q[k] <= store_d[k];
      end
    end
  end

  // outputs past the configured channel count read as zero
  always_comb begin
    for (int k = 0; k < OutChans; k++) begin
      chans[k] = '0;
      if (k < NUM_CHANNELS) begin
        chans[k] = store_d[k];
      end
    end
  end

  always_comb begin
    result_o.chan0      = chans[0];
    result_o.chan1      = chans[1];
    result_o.chan2      = chans[2];
    result_o.chan3      = chans[3];
    result_o.chan4      = chans[4];
    result_o.chan5      = chans[5];
    result_o.chan6      = chans[6];
    result_o.chan7      = chans[7];
    result_o.chan8      = chans[8];
    result_o.frame_done = done;
    result_o.link_ok    = (ticks_d <= {1'b0, cfg_i.timeout_ms});
  end

endmodule

[hw/rtl/rcsat_outbuf.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcsat_outbuf
// Result register with a skid stage, so the input side can take one more beat
// while a result waits at the output.
// ----------------------------------------------------------------------------
module rcsat_outbuf import rcsat_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  rcsat_out_t push_data_i,
  output logic       full_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output rcsat_out_t out_data_o
);

  logic       out_valid_q, out_valid_d;
  logic       skid_valid_q, skid_valid_d;
  rcsat_out_t out_q, out_d;
  rcsat_out_t skid_q, skid_d;
  logic       pop;

  assign pop = out_valid_q && !out_stall_i;

  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_d        = out_q;
    skid_d       = skid_q;
    if (!out_valid_q || pop) begin
      if (skid_valid_q) begin
        out_d        = skid_q;
        out_valid_d  = 1'b1;
        skid_valid_d = 1'b0;
      end else begin
        out_d       = push_data_i;
        out_valid_d = push_i;
      end
    end else if (push_i) begin
      skid_d       = push_data_i;
      skid_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign full_o      = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

[hw/rtl/rcsat_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcsat_checker
// Port-level checks on the frame decoder, attached by bind.
// ----------------------------------------------------------------------------
module rcsat_checker import rcsat_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input rcsat_out_t out_data_o,
  input logic       out_valid_o,
  input logic       out_stall_i
);

  // a stalled result beat holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result beat changed");

  // input backpressure only follows an output stall
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> $past(out_valid_o && out_stall_i))
    else $error("input stalled without output stall");

  // completing a frame clears the tick count, so the link is good
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.frame_done |-> out_data_o.link_ok)
    else $error("frame done with link lost");

  // an accepted beat into an empty output shows next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && !out_valid_o |=> out_valid_o)
    else $error("accepted beat did not reach output");

endmodule

bind rc_satellite_frame_decoder_top rcsat_checker u_rcsat_checker (.*);
